// File: rtl/nttp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttp_pkg: shared types and constants of the note to tone period block
// Field widths, configuration register indexes and reset values, and the
// table of octave-4 note frequencies in unsigned Q.24 hertz.
// ----------------------------------------------------------------------------
package nttp_pkg;

    // Input and configuration field widths
    localparam int OCT_W      = 4;
    localparam int SEMI_W     = 4;
    localparam int CLK_W      = 26;
    localparam int DIV_W      = 8;
    localparam int OFS_W      = 8;
    localparam int MAX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam int IN_TDATA_W = 8;

    // Octave that holds the table frequencies
    localparam logic [OCT_W-1:0] OCT_REF = 4'd4;
    localparam logic [SEMI_W-1:0] SEMIS_PER_OCT = 4'd12;

    // Frequency table format
    localparam int TABLE_FRAC = 24;
    localparam int TABLE_W    = 34;
    localparam int NOTES      = 12;

    // Quotient width: the largest rounded period stays below 2^22
    localparam int QUO_W = 24;
    localparam int VAL_W = QUO_W + 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD    = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CLK_W-1:0] RST_CLOCK_HZ      = 26'd3579545;
    localparam logic [DIV_W-1:0] RST_CLOCK_DIVISOR = 8'd32;
    localparam logic [OFS_W-1:0] RST_PERIOD_OFFSET = 8'd0;
    localparam logic [MAX_W-1:0] RST_MAX_PERIOD    = 16'd4095;

    // 440 * 2^((s - 9) / 12) Hz, s = 0 (C) .. 11 (B), in Q.24
    localparam logic [TABLE_W-1:0] NOTE_Q24 [NOTES] = '{
        34'd4389348620, 34'd4650352871, 34'd4926877243, 34'd5219844609,
        34'd5530232722, 34'd5859077472, 34'd6207476349, 34'd6576592100,
        34'd6967656617, 34'd7381975040, 34'd7820930118, 34'd8285986824
    };

    typedef struct packed {
        logic [CLK_W-1:0] clock_hz;
        logic [DIV_W-1:0] clock_divisor;
        logic [OFS_W-1:0] period_offset;
        logic [MAX_W-1:0] max_period;
    } t_cfg;

endpackage

// File: rtl/nttp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttp_front: note frequency lookup and divider operand set-up
// Three register stages: table lookup, prescaler multiply, and the octave
// shifts that give the rounded-division dividend and divisor.
// ----------------------------------------------------------------------------
module nttp_front #(
    parameter int FREQ_FRAC_BITS = 16,
    parameter int N_W            = 48,
    parameter int D_W            = 45
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nttp_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [nttp_pkg::OCT_W-1:0]   i_octave,
    input  logic [nttp_pkg::SEMI_W-1:0]  i_semitone,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [N_W-1:0]               o_n,
    output logic [D_W-1:0]               o_d
);

    localparam int SH      = nttp_pkg::TABLE_FRAC - FREQ_FRAC_BITS;
    localparam int F_W     = FREQ_FRAC_BITS + 9;
    localparam int DEN0_W  = nttp_pkg::DIV_W + F_W;
    localparam int DEN_W   = DEN0_W + 11;
    localparam int NUM_W   = nttp_pkg::CLK_W + FREQ_FRAC_BITS + 4;
    localparam logic [nttp_pkg::TABLE_W-1:0] HALF =
        (SH == 0) ? '0 : nttp_pkg::TABLE_W'(64'd1 << (SH - 1));

    // Stage A: frequency lookup
    logic                        r_a_valid;
    logic [F_W-1:0]              r_a_f;
    logic [nttp_pkg::OCT_W-1:0]  r_a_oct;
    // Stage B: prescaler times frequency
    logic                        r_b_valid;
    logic [DEN0_W-1:0]           r_b_den0;
    logic [nttp_pkg::OCT_W-1:0]  r_b_oct;
    // Stage C: dividend and divisor
    logic                        r_c_valid;
    logic [N_W-1:0]              r_c_n;
    logic [D_W-1:0]              r_c_d;

    logic a_ready, b_ready, c_ready;
    logic [nttp_pkg::SEMI_W-1:0]  semi_idx;
    logic [nttp_pkg::TABLE_W-1:0] f_sum;
    logic [2:0]                   num_sh;
    logic [3:0]                   den_sh;
    logic [NUM_W-1:0]             num;
    logic [DEN_W-1:0]             den;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Semitones twelve and above wrap into the same octave
    always_comb begin
        semi_idx = (i_semitone >= nttp_pkg::SEMIS_PER_OCT) ?
                   i_semitone - nttp_pkg::SEMIS_PER_OCT : i_semitone;
        f_sum    = nttp_pkg::NOTE_Q24[semi_idx] + HALF;
    end

    always_comb begin
        if (r_b_oct < nttp_pkg::OCT_REF) begin
            num_sh = 3'(nttp_pkg::OCT_REF - r_b_oct);
            den_sh = '0;
        end else begin
            num_sh = '0;
            den_sh = r_b_oct - nttp_pkg::OCT_REF;
        end
        num = (NUM_W'(i_cfg.clock_hz) << FREQ_FRAC_BITS) << num_sh;
        den = DEN_W'(r_b_den0) << den_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_f   <= F_W'(f_sum >> SH);
            r_a_oct <= i_octave;
        end
        if (b_ready) begin
            r_b_den0 <= DEN0_W'(i_cfg.clock_divisor) * DEN0_W'(r_a_f);
            r_b_oct  <= r_a_oct;
        end
        if (c_ready) begin
            // Adding the divisor once gives a quotient rounded half up
            r_c_n <= N_W'({num, 1'b0}) + N_W'(den);
            r_c_d <= D_W'({den, 1'b0});
        end
    end

    assign o_valid = r_c_valid;
    assign o_n     = r_c_n;
    assign o_d     = r_c_d;

endmodule

// File: rtl/nttp_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttp_div_stage: one step of the restoring divider
// Brings down the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit in where the dividend bit left.
// ----------------------------------------------------------------------------
module nttp_div_stage #(
    parameter int REM_W = 45,
    parameter int QUO_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_qn,
    input  logic [REM_W-1:0]  i_d,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [REM_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_qn,
    output logic [REM_W-1:0]  o_d
);

    logic               r_valid;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_qn;
    logic [REM_W-1:0]   r_d;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           fits;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        trial = {i_rem, i_qn[QUO_W-1]};
        diff  = trial - {1'b0, i_d};
        fits  = trial >= {1'b0, i_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            r_qn  <= {i_qn[QUO_W-2:0], fits};
            r_d   <= i_d;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_qn    = r_qn;
    assign o_d     = r_d;

endmodule

// File: rtl/nttp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nttp_back: offset, range check and output register
// Adds the signed offset to the rounded quotient, flags values above the
// configured maximum and saturates to the period width.
// ----------------------------------------------------------------------------
module nttp_back #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nttp_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [nttp_pkg::QUO_W-1:0]  i_quo,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [PERIOD_BITS-1:0]      o_period,
    output logic                        o_over_max,
    output logic                        o_clipped
);

    localparam int VW = nttp_pkg::VAL_W;

    logic                    r_valid;
    logic [PERIOD_BITS-1:0]  r_period;
    logic                    r_over;
    logic                    r_clip;

    logic signed [VW-1:0]    val;
    logic signed [VW-1:0]    limit;
    logic signed [VW-1:0]    max_val;
    logic [PERIOD_BITS-1:0]  n_period;
    logic                    n_over;
    logic                    n_clip;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        val     = $signed({2'b00, i_quo}) +
                  $signed({{(VW - nttp_pkg::OFS_W){i_cfg.period_offset[nttp_pkg::OFS_W-1]}},
                           i_cfg.period_offset});
        limit   = $signed({{(VW - PERIOD_BITS){1'b0}}, {PERIOD_BITS{1'b1}}});
        max_val = $signed({{(VW - nttp_pkg::MAX_W){1'b0}}, i_cfg.max_period});
        if (i_cfg.clock_divisor == '0) begin
            // A zero prescaler stands for an unbounded period.
            n_period = '1;
            n_over   = 1'b1;
            n_clip   = 1'b1;
        end else begin
            n_over = val > max_val;
            if (val < 0) begin
                n_period = '0;
                n_clip   = 1'b1;
            end else if (val > limit) begin
                n_period = '1;
                n_clip   = 1'b1;
            end else begin
                n_period = val[PERIOD_BITS-1:0];
                n_clip   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_period <= n_period;
            r_over   <= n_over;
            r_clip   <= n_clip;
        end
    end

    assign o_valid    = r_valid;
    assign o_period   = r_period;
    assign o_over_max = r_over;
    assign o_clipped  = r_clip;

endmodule

// File: rtl/note_to_tone_period.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_to_tone_period: equal-temperament note to tone generator period
// Turns an octave and semitone into round(clock / (divisor * freq)) plus a
// signed offset, with an over-maximum flag and saturation to the period width.
// ----------------------------------------------------------------------------
// The block takes one note a cycle unless its full pipeline is held at the
// output, and returns each period through table lookup, prescaler multiply
// and operand set-up, a restoring divider stage for each of the 24 quotient
// bits, and the output register. Every stage holds its item while the stage
// after it is full and stalled, so an empty stage anywhere in the pipeline
// lets a new note in even while a result waits at the output. Configuration
// registers are written through the plain write port and should change only
// while no note is in flight.
module note_to_tone_period #(
    parameter int FREQ_FRAC_BITS = 16,
    parameter int PERIOD_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [nttp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nttp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Note requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] octave, [7:4] semitone
    input  logic [nttp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Periods
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [PERIOD_BITS-1:0] period, then over_max, then clipped, zero padded
    output logic [((PERIOD_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_W = ((PERIOD_BITS + 2 + 7) / 8) * 8;
    localparam int QW    = nttp_pkg::QUO_W;
    localparam int N_W   = FREQ_FRAC_BITS + 32;
    localparam int D_W   = FREQ_FRAC_BITS + 29;
    localparam int HI_W  = N_W - QW;

    nttp_pkg::t_cfg r_cfg;

    logic              front_valid;
    logic [N_W-1:0]    front_n;
    logic [D_W-1:0]    front_d;

    logic              w_valid [QW+1];
    logic              w_ready [QW+1];
    logic [D_W-1:0]    w_rem   [QW+1];
    logic [QW-1:0]     w_qn    [QW+1];
    logic [D_W-1:0]    w_d     [QW+1];

    logic [PERIOD_BITS-1:0] out_period;
    logic                   out_over;
    logic                   out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_hz      <= nttp_pkg::RST_CLOCK_HZ;
            r_cfg.clock_divisor <= nttp_pkg::RST_CLOCK_DIVISOR;
            r_cfg.period_offset <= nttp_pkg::RST_PERIOD_OFFSET;
            r_cfg.max_period    <= nttp_pkg::RST_MAX_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nttp_pkg::CFG_CLOCK_HZ: begin
                    r_cfg.clock_hz <= i_cfg_data[nttp_pkg::CLK_W-1:0];
                end
                nttp_pkg::CFG_CLOCK_DIVISOR: begin
                    r_cfg.clock_divisor <= i_cfg_data[nttp_pkg::DIV_W-1:0];
                end
                nttp_pkg::CFG_PERIOD_OFFSET: begin
                    r_cfg.period_offset <= i_cfg_data[nttp_pkg::OFS_W-1:0];
                end
                nttp_pkg::CFG_MAX_PERIOD: begin
                    r_cfg.max_period <= i_cfg_data[nttp_pkg::MAX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    nttp_front #(
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS),
        .N_W            (N_W),
        .D_W            (D_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_octave   (s_axis_tdata[nttp_pkg::OCT_W-1:0]),
        .i_semitone (s_axis_tdata[nttp_pkg::OCT_W +: nttp_pkg::SEMI_W]),
        .o_valid    (front_valid),
        .i_ready    (w_ready[0]),
        .o_n        (front_n),
        .o_d        (front_d)
    );

    // The upper dividend bits start as the partial remainder; the lower bits
    // are brought down one per stage and give way to the quotient bits.
    assign w_valid[0] = front_valid;
    assign w_rem[0]   = {{(D_W - HI_W){1'b0}}, front_n[N_W-1:QW]};
    assign w_qn[0]    = front_n[QW-1:0];
    assign w_d[0]     = front_d;

    for (genvar g = 0; g < QW; g++) begin : g_div
        nttp_div_stage #(
            .REM_W (D_W),
            .QUO_W (QW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_rem   (w_rem[g]),
            .i_qn    (w_qn[g]),
            .i_d     (w_d[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_qn    (w_qn[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    nttp_back #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_valid[QW]),
        .o_ready    (w_ready[QW]),
        .i_quo      (w_qn[QW]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_period   (out_period),
        .o_over_max (out_over),
        .o_clipped  (out_clip)
    );

    assign m_axis_tdata = OUT_W'({out_clip, out_over, out_period});

endmodule
